@@ src/ifdc_pkg.sv @@
package ifdc_pkg;

  localparam int DATA_W          = 8;
  localparam int LEN_W           = 11;
  localparam int KIND_W          = 2;
  localparam int CFG_IDX_W       = 3;
  localparam int QUEUE_DEPTH     = 2;
  localparam int MAX_PAYLOAD_DEF = 1024;

  localparam logic [DATA_W-1:0] STUFF_XOR = 8'h20;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GOOD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BAD  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FLAG      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CMD_ADDR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RESP_ADDR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INFO_CTL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_CTL   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NACK_CTL  = 3'd6;

  localparam logic [DATA_W-1:0] FLAG_RST      = 8'h7E;
  localparam logic [DATA_W-1:0] ESCAPE_RST    = 8'h7D;
  localparam logic [DATA_W-1:0] CMD_ADDR_RST  = 8'h03;
  localparam logic [DATA_W-1:0] RESP_ADDR_RST = 8'h01;
  localparam logic [DATA_W-1:0] INFO_CTL_RST  = 8'h00;
  localparam logic [DATA_W-1:0] ACK_CTL_RST   = 8'h05;
  localparam logic [DATA_W-1:0] NACK_CTL_RST  = 8'h01;

  typedef struct packed {
    logic [DATA_W-1:0] flag;
    logic [DATA_W-1:0] escape;
    logic [DATA_W-1:0] cmd_addr;
    logic [DATA_W-1:0] info_ctl;
    logic [DATA_W-1:0] ack_ctl;
    logic [DATA_W-1:0] nack_ctl;
  } ifdc_cfg_t;

  // one received byte with its compare results
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              is_flag;
    logic              is_esc;
    logic              is_addr;
    logic              is_ictl0;
    logic              is_ictl1;
    logic              is_bcc0;
    logic              is_bcc1;
  } ifdc_class_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] value;
    logic              seq;
    logic [LEN_W-1:0]  len;
    logic              frame_end;
  } ifdc_result_t;

  typedef enum logic [4:0] {
    ST_HUNT = 5'b00001,
    ST_FLAG = 5'b00010,
    ST_ADDR = 5'b00100,
    ST_CTRL = 5'b01000,
    ST_DATA = 5'b10000
  } ifdc_state_t;

endpackage

@@ src/ifdc_fifo.sv @@
module ifdc_fifo
  import ifdc_pkg::*;
#(
  parameter int W     = DATA_W,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ src/ifdc_front.sv @@
module ifdc_front
  import ifdc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ifdc_cfg_t         cfg,
  input  logic              push,
  input  logic [DATA_W-1:0] rx_byte,
  output logic              full,
  input  logic              pop,
  output ifdc_class_t       item,
  output logic              empty
);

  ifdc_class_t       cls;
  logic [DATA_W-1:0] ictl0, ictl1;

  // info control with the sequence bit at bit 6
  assign ictl0 = cfg.info_ctl;
  assign ictl1 = cfg.info_ctl | 8'h40;

  always_comb begin
    cls.value    = rx_byte;
    cls.is_flag  = (rx_byte == cfg.flag);
    cls.is_esc   = (rx_byte == cfg.escape);
    cls.is_addr  = (rx_byte == cfg.cmd_addr);
    cls.is_ictl0 = (rx_byte == ictl0);
    cls.is_ictl1 = (rx_byte == ictl1);
    cls.is_bcc0  = (rx_byte == (ictl0 ^ cfg.cmd_addr));
    cls.is_bcc1  = (rx_byte == (ictl1 ^ cfg.cmd_addr));
  end

  ifdc_fifo #(
    .W     ($bits(ifdc_class_t)),
    .DEPTH (DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (cls),
    .full  (full),
    .pop   (pop),
    .dout  (item),
    .empty (empty)
  );

endmodule

@@ src/ifdc_back.sv @@
module ifdc_back
  import ifdc_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  ifdc_cfg_t    cfg,
  input  ifdc_class_t  item,
  input  logic         item_empty,
  output logic         item_pop,
  input  logic         res_full,
  output logic         res_valid,
  output ifdc_result_t res
);

  // count must hold the overflow mark MAX_PAYLOAD + 1
  localparam int CNT_W = $clog2(MAX_PAYLOAD + 2);

  ifdc_state_t       state_r, state_nxt;
  logic              rx_seq_r, rx_seq_nxt;
  logic              esc_r, esc_nxt;
  logic [DATA_W-1:0] held_r, held_nxt;
  logic              held_vld_r, held_vld_nxt;
  logic [DATA_W-1:0] parity_r, parity_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              reply_seq_r, reply_seq_nxt;

  logic              take;
  logic [DATA_W-1:0] take_byte;
  logic              emit;
  logic              overflow, good;
  logic [CNT_W-1:0]  len_sel;
  ifdc_state_t       fail_state;

  assign item_pop   = !item_empty && !res_full;
  assign res_valid  = item_pop && emit;
  assign fail_state = item.is_flag ? ST_FLAG : ST_HUNT;
  assign overflow   = (count_r > CNT_W'(MAX_PAYLOAD));
  assign good       = held_vld_r && (count_r != '0) && !overflow && !esc_r
                      && (held_r == parity_r);
  assign len_sel    = overflow ? CNT_W'(MAX_PAYLOAD) : count_r;

  always_comb begin
    state_nxt     = state_r;
    rx_seq_nxt    = rx_seq_r;
    esc_nxt       = esc_r;
    held_nxt      = held_r;
    held_vld_nxt  = held_vld_r;
    parity_nxt    = parity_r;
    count_nxt     = count_r;
    reply_seq_nxt = reply_seq_r;
    take          = 1'b0;
    take_byte     = item.value;
    emit          = 1'b0;
    res.kind      = KIND_DATA;
    res.value     = held_r;
    res.seq       = rx_seq_r;
    res.len       = '0;
    res.frame_end = 1'b0;

    case (state_r)
      ST_FLAG: begin
        state_nxt = item.is_addr ? ST_ADDR : fail_state;
      end
      ST_ADDR: begin
        if (item.is_ictl0) begin
          rx_seq_nxt = 1'b0;
          state_nxt  = ST_CTRL;
        end else if (item.is_ictl1) begin
          rx_seq_nxt = 1'b1;
          state_nxt  = ST_CTRL;
        end else begin
          state_nxt = fail_state;
        end
      end
      ST_CTRL: begin
        if (rx_seq_r ? item.is_bcc1 : item.is_bcc0) begin
          state_nxt    = ST_DATA;
          esc_nxt      = 1'b0;
          held_nxt     = '0;
          held_vld_nxt = 1'b0;
          parity_nxt   = '0;
          count_nxt    = '0;
        end else begin
          state_nxt = fail_state;
        end
      end
      ST_DATA: begin
        if (item.is_flag) begin
          // closing flag wins even right after an escape
          emit          = 1'b1;
          res.kind      = good ? KIND_GOOD : KIND_BAD;
          res.value     = (good ? cfg.ack_ctl : cfg.nack_ctl) | {reply_seq_r, 7'd0};
          res.len       = LEN_W'(len_sel);
          res.frame_end = 1'b1;
          if (good) begin
            reply_seq_nxt = !reply_seq_r;
          end
          esc_nxt      = 1'b0;
          held_vld_nxt = 1'b0;
          state_nxt    = ST_HUNT;
        end else if (esc_r) begin
          esc_nxt   = 1'b0;
          take      = 1'b1;
          take_byte = item.value ^ STUFF_XOR;
        end else if (item.is_esc) begin
          esc_nxt = 1'b1;
        end else begin
          take = 1'b1;
        end
      end
      default: begin
        state_nxt = item.is_flag ? ST_FLAG : ST_HUNT;
      end
    endcase

    // one-byte hold: the byte before the closing flag is BCC2
    if (take) begin
      if (held_vld_r) begin
        if (count_r < CNT_W'(MAX_PAYLOAD)) begin
          emit       = 1'b1;
          parity_nxt = parity_r ^ held_r;
          count_nxt  = count_r + 1'b1;
        end else begin
          count_nxt = CNT_W'(MAX_PAYLOAD + 1);
        end
      end
      held_nxt     = take_byte;
      held_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_HUNT;
      rx_seq_r    <= 1'b0;
      esc_r       <= 1'b0;
      held_r      <= '0;
      held_vld_r  <= 1'b0;
      parity_r    <= '0;
      count_r     <= '0;
      reply_seq_r <= 1'b1;
    end else if (item_pop) begin
      state_r     <= state_nxt;
      rx_seq_r    <= rx_seq_nxt;
      esc_r       <= esc_nxt;
      held_r      <= held_nxt;
      held_vld_r  <= held_vld_nxt;
      parity_r    <= parity_nxt;
      count_r     <= count_nxt;
      reply_seq_r <= reply_seq_nxt;
    end
  end

endmodule

@@ src/info_frame_deframer_checker.sv @@
// Path: a byte transferred into the input queue is taken by the frame engine,
//   which writes its result (if any) into the result queue that drives the out_ ports.
// Throughput: one byte per cycle sustained while the result queue has room; the
//   frame engine handles one queued byte per cycle and stalls while that queue is full.
// Reset (rst_n low, synchronous): config registers return to defaults, both
//   queues empty, frame engine hunts for a flag, reply sequence set to one.
module info_frame_deframer_checker
  import ifdc_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  parameter int DEPTH       = QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // config write port
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata,
  // byte input (queue style)
  input  logic                 push,
  input  logic [DATA_W-1:0]    in_rx_byte,
  output logic                 full,
  // results (queue style)
  input  logic                 pop,
  output logic                 empty,
  output logic [KIND_W-1:0]    out_kind,
  output logic [DATA_W-1:0]    out_byte,
  output logic                 out_frame_seq,
  output logic [LEN_W-1:0]     out_payload_len,
  output logic                 out_frame_end
);

  ifdc_cfg_t    cfg_r;
  ifdc_class_t  item;
  logic         item_empty, item_pop;
  logic         res_full, res_valid;
  ifdc_result_t res, res_head;

  // Config registers. The response address register is write-only in effect:
  // replies are not built here, so its writes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flag     <= FLAG_RST;
      cfg_r.escape   <= ESCAPE_RST;
      cfg_r.cmd_addr <= CMD_ADDR_RST;
      cfg_r.info_ctl <= INFO_CTL_RST;
      cfg_r.ack_ctl  <= ACK_CTL_RST;
      cfg_r.nack_ctl <= NACK_CTL_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FLAG:      cfg_r.flag     <= cfg_wdata;
        REG_ESCAPE:    cfg_r.escape   <= cfg_wdata;
        REG_CMD_ADDR:  cfg_r.cmd_addr <= cfg_wdata;
        REG_RESP_ADDR: ;
        REG_INFO_CTL:  cfg_r.info_ctl <= cfg_wdata;
        REG_ACK_CTL:   cfg_r.ack_ctl  <= cfg_wdata;
        REG_NACK_CTL:  cfg_r.nack_ctl <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Front: compares each byte against the config and queues it with its flags.
  ifdc_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .push    (push),
    .rx_byte (in_rx_byte),
    .full    (full),
    .pop     (item_pop),
    .item    (item),
    .empty   (item_empty)
  );

  // Back: header checks, un-stuffing, BCC2 hold and end-of-frame verdict.
  ifdc_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item       (item),
    .item_empty (item_empty),
    .item_pop   (item_pop),
    .res_full   (res_full),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Result queue decouples the engine from the consumer's pop.
  ifdc_fifo #(
    .W     ($bits(ifdc_result_t)),
    .DEPTH (DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_valid),
    .din   (res),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_head),
    .empty (empty)
  );

  assign out_kind        = res_head.kind;
  assign out_byte        = res_head.value;
  assign out_frame_seq   = res_head.seq;
  assign out_payload_len = res_head.len;
  assign out_frame_end   = res_head.frame_end;

  // engine never writes a full result queue
  a_no_res_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(res_valid && res_full))
    else $error("result written into full queue");

  // engine only steps on a queued byte
  a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    item_pop |-> !item_empty)
    else $error("engine stepped with empty input queue");

  // both queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queues not empty after reset");

  // payload transfers carry no end mark and no length
  a_payload_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind == KIND_DATA) |-> (!out_frame_end && out_payload_len == '0))
    else $error("payload result with end fields set");

endmodule

@@ test/ifdc_frame_checker.sv @@
module ifdc_frame_checker
  import ifdc_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata,
  input  logic                 push,
  input  logic [DATA_W-1:0]    in_rx_byte,
  input  logic                 full,
  input  logic                 pop,
  input  logic                 empty,
  input  logic [KIND_W-1:0]    out_kind,
  input  logic [DATA_W-1:0]    out_byte,
  input  logic                 out_frame_seq,
  input  logic [LEN_W-1:0]     out_payload_len,
  input  logic                 out_frame_end,
  output int                   fail_count,
  output int                   pending,
  output int                   data_seen,
  output int                   good_seen,
  output int                   bad_seen
);

  // mirrored registers
  ifdc_cfg_t         regs;
  logic [DATA_W-1:0] resp_addr;

  // deframer state
  ifdc_state_t       frame_state;
  logic              seq_bit;
  logic              esc_armed;
  logic [DATA_W-1:0] held_octet;
  logic              held_ok;
  logic [DATA_W-1:0] xor_sum;
  int                octet_count;
  logic              reply_bit;

  ifdc_result_t      expected_q[$];
  int                results_seen = 0;

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("mismatch at result %0d: %s expected 0x%0h, got 0x%0h",
             results_seen, what, want, got);
    fail_count++;
  endtask

  function automatic logic [DATA_W-1:0] info_ctl(input logic s);
    return regs.info_ctl | {1'b0, s, 6'b0};
  endfunction

  function automatic void header_miss(input logic [DATA_W-1:0] b);
    frame_state = (b == regs.flag) ? ST_FLAG : ST_HUNT;
  endfunction

  // one un-escaped octet; the previously held one goes out as payload while under the limit
  function automatic bit take_octet(input logic [DATA_W-1:0] x, output ifdc_result_t r);
    bit got;
    got = 1'b0;
    r = '0;
    if (held_ok) begin
      if (octet_count < MAX_PAYLOAD) begin
        r.kind = KIND_DATA;
        r.value = held_octet;
        r.seq = seq_bit;
        xor_sum ^= held_octet;
        octet_count++;
        got = 1'b1;
      end else begin
        octet_count = MAX_PAYLOAD + 1;
      end
    end
    held_octet = x;
    held_ok = 1'b1;
    return got;
  endfunction

  function automatic bit deframe_octet(input logic [DATA_W-1:0] b, output ifdc_result_t r);
    bit overflow, good;
    r = '0;
    case (frame_state)
      ST_FLAG: begin
        if (b == regs.cmd_addr) frame_state = ST_ADDR;
        else header_miss(b);
        return 1'b0;
      end
      ST_ADDR: begin
        if (b == info_ctl(1'b0)) begin
          seq_bit = 1'b0;
          frame_state = ST_CTRL;
        end else if (b == info_ctl(1'b1)) begin
          seq_bit = 1'b1;
          frame_state = ST_CTRL;
        end else begin
          header_miss(b);
        end
        return 1'b0;
      end
      ST_CTRL: begin
        if (b == (info_ctl(seq_bit) ^ regs.cmd_addr)) begin
          frame_state = ST_DATA;
          esc_armed = 1'b0;
          held_octet = '0;
          held_ok = 1'b0;
          xor_sum = '0;
          octet_count = 0;
        end else begin
          header_miss(b);
        end
        return 1'b0;
      end
      ST_DATA: begin
        if (b == regs.flag) begin
          overflow = octet_count > MAX_PAYLOAD;
          good = held_ok && octet_count != 0 && !overflow && !esc_armed &&
                 held_octet == xor_sum;
          r.kind = good ? KIND_GOOD : KIND_BAD;
          r.value = (good ? regs.ack_ctl : regs.nack_ctl) | {reply_bit, 7'b0};
          r.seq = seq_bit;
          r.len = LEN_W'(overflow ? MAX_PAYLOAD : octet_count);
          r.frame_end = 1'b1;
          if (good) reply_bit = ~reply_bit;
          esc_armed = 1'b0;
          held_ok = 1'b0;
          frame_state = ST_HUNT;
          return 1'b1;
        end
        if (esc_armed) begin
          esc_armed = 1'b0;
          return take_octet(b ^ STUFF_XOR, r);
        end
        if (b == regs.escape) begin
          esc_armed = 1'b1;
          return 1'b0;
        end
        return take_octet(b, r);
      end
      default: begin
        frame_state = (b == regs.flag) ? ST_FLAG : ST_HUNT;
        return 1'b0;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    ifdc_result_t want, got, nxt;
    if (!rst_n) begin
      regs = '{flag: FLAG_RST, escape: ESCAPE_RST, cmd_addr: CMD_ADDR_RST,
               info_ctl: INFO_CTL_RST, ack_ctl: ACK_CTL_RST, nack_ctl: NACK_CTL_RST};
      resp_addr = RESP_ADDR_RST;
      frame_state = ST_HUNT;
      seq_bit = 1'b0;
      esc_armed = 1'b0;
      held_octet = '0;
      held_ok = 1'b0;
      xor_sum = '0;
      octet_count = 0;
      reply_bit = 1'b1;
      expected_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_FLAG:      regs.flag = cfg_wdata;
          REG_ESCAPE:    regs.escape = cfg_wdata;
          REG_CMD_ADDR:  regs.cmd_addr = cfg_wdata;
          REG_RESP_ADDR: resp_addr = cfg_wdata;
          REG_INFO_CTL:  regs.info_ctl = cfg_wdata;
          REG_ACK_CTL:   regs.ack_ctl = cfg_wdata;
          REG_NACK_CTL:  regs.nack_ctl = cfg_wdata;
          default: ;
        endcase
      end
      // results lag their byte, so the result side goes first
      if (pop && !empty) begin
        got = '{kind: out_kind, value: out_byte, seq: out_frame_seq,
                len: out_payload_len, frame_end: out_frame_end};
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing expected", '0, 32'(got));
        end else begin
          want = expected_q.pop_front();
          if (got.kind !== want.kind)
            report_mismatch("out_kind", 32'(want.kind), 32'(got.kind));
          if (got.value !== want.value)
            report_mismatch("out_byte", 32'(want.value), 32'(got.value));
          if (got.seq !== want.seq)
            report_mismatch("out_frame_seq", 32'(want.seq), 32'(got.seq));
          if (got.len !== want.len)
            report_mismatch("out_payload_len", 32'(want.len), 32'(got.len));
          if (got.frame_end !== want.frame_end)
            report_mismatch("out_frame_end", 32'(want.frame_end), 32'(got.frame_end));
          case (want.kind)
            KIND_DATA: data_seen++;
            KIND_GOOD: good_seen++;
            default:   bad_seen++;
          endcase
        end
        results_seen++;
      end
      if (push && !full) begin
        if (deframe_octet(in_rx_byte, nxt)) expected_q.push_back(nxt);
      end
    end
    pending = expected_q.size();
  end

endmodule

@@ test/tb_info_frame_deframer_checker.sv @@
module tb_info_frame_deframer_checker;
  import ifdc_pkg::*;

  // Spare register index: writes there must leave every result unchanged.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  localparam int N_PHASES    = 6;
  localparam int PHASE_ITEMS = 125;
  localparam int IDLE_PCT    = 31;
  // Slowest run is a few thousand bytes; take it many times over.
  localparam int CYCLE_LIMIT = 300000;

  typedef logic [DATA_W-1:0] octet_q_t[$];

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_wdata = '0;
  logic                 push = 1'b0;
  logic [DATA_W-1:0]    in_rx_byte = '0;
  logic                 full;
  logic                 pop = 1'b0;
  logic                 empty;
  logic [KIND_W-1:0]    out_kind;
  logic [DATA_W-1:0]    out_byte;
  logic                 out_frame_seq;
  logic [LEN_W-1:0]     out_payload_len;
  logic                 out_frame_end;

  int fail_count, pending, data_seen, good_seen, bad_seen;

  // Current register values as the stimulus side sees them; frames are
  // built from these.
  ifdc_cfg_t         cur = '{flag: FLAG_RST, escape: ESCAPE_RST, cmd_addr: CMD_ADDR_RST,
                             info_ctl: INFO_CTL_RST, ack_ctl: ACK_CTL_RST,
                             nack_ctl: NACK_CTL_RST};
  logic [DATA_W-1:0] resp_val = RESP_ADDR_RST;

  int src_idle = IDLE_PCT;   // sender gap chance, percent
  int sink_idle = IDLE_PCT;  // receiver stall chance, percent; changed by NBA only
  int sent = 0;              // accepted input transfers
  int cycle_count = 0;

  always #6 clk = ~clk;

  info_frame_deframer_checker dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .push(push), .in_rx_byte(in_rx_byte), .full(full),
    .pop(pop), .empty(empty),
    .out_kind(out_kind), .out_byte(out_byte), .out_frame_seq(out_frame_seq),
    .out_payload_len(out_payload_len), .out_frame_end(out_frame_end)
  );

  ifdc_frame_checker frame_chk (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .push(push), .in_rx_byte(in_rx_byte), .full(full),
    .pop(pop), .empty(empty),
    .out_kind(out_kind), .out_byte(out_byte), .out_frame_seq(out_frame_seq),
    .out_payload_len(out_payload_len), .out_frame_end(out_frame_end),
    .fail_count(fail_count), .pending(pending),
    .data_seen(data_seen), .good_seen(good_seen), .bad_seen(bad_seen)
  );

  // Receiver: free-running pop with random stalls.
  always @(posedge clk) pop <= ($urandom_range(99) >= sink_idle);

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_info_frame_deframer_checker failed");
      $finish;
    end
  end

  // One input transfer. Called right after a rising edge; returns right after
  // the edge that took the byte. push is left high so back-to-back bytes never
  // see a low-then-high in one step.
  task automatic send_byte(input logic [DATA_W-1:0] b);
    while ($urandom_range(99) < src_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_rx_byte <= b;
    // full read here is the value the edge just sampled
    do @(posedge clk); while (full);
    sent++;
  endtask

  // Byte stuffing: flag and escape values go out as escape, value ^ 0x20.
  task automatic send_stuffed(input logic [DATA_W-1:0] b);
    if (b == cur.flag || b == cur.escape) begin
      send_byte(cur.escape);
      send_byte(b ^ STUFF_XOR);
    end else begin
      send_byte(b);
    end
  endtask

  // Opening flag, address, control, BCC1, stuffed payload, optional BCC2
  // (possibly corrupted), optional dangling escape, closing flag.
  task automatic send_frame(input logic seq, input octet_q_t pay, input bit with_bcc,
                            input logic [DATA_W-1:0] bcc_flip, input bit tail_esc);
    logic [DATA_W-1:0] ctl, sum;
    ctl = cur.info_ctl | {1'b0, seq, 6'b0};
    sum = '0;
    send_byte(cur.flag);
    send_byte(cur.cmd_addr);
    send_byte(ctl);
    send_byte(ctl ^ cur.cmd_addr);
    foreach (pay[i]) begin
      send_stuffed(pay[i]);
      sum ^= pay[i];
    end
    if (with_bcc) send_stuffed(sum ^ bcc_flip);
    if (tail_esc) send_byte(cur.escape);
    send_byte(cur.flag);
  endtask

  // Sender holds off until every expected result has been popped, then gives
  // the block time to finish bytes that produce no result.
  task automatic wait_idle();
    push <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic apply_config();
    write_reg(REG_FLAG, cur.flag);
    write_reg(REG_ESCAPE, cur.escape);
    write_reg(REG_CMD_ADDR, cur.cmd_addr);
    write_reg(REG_RESP_ADDR, resp_val);
    write_reg(REG_INFO_CTL, cur.info_ctl);
    write_reg(REG_ACK_CTL, cur.ack_ctl);
    write_reg(REG_NACK_CTL, cur.nack_ctl);
    write_reg(REG_SPARE, DATA_W'($urandom_range(255)));
    cfg_wr_en <= 1'b0;
  endtask

  // Random payload, biased toward the flag and escape values so stuffing
  // is exercised often.
  function automatic logic [DATA_W-1:0] pick_octet();
    case ($urandom_range(9))
      0:       return cur.flag;
      1:       return cur.escape;
      default: return DATA_W'($urandom_range(255));
    endcase
  endfunction

  // Mostly well-formed frames with random content; the rest are bad BCC2,
  // empty payloads, an escape left open at the closing flag, header damage
  // and raw line noise.
  task automatic send_random_frame();
    octet_q_t          pay;
    logic [DATA_W-1:0] hdr[4];
    logic [DATA_W-1:0] ctl, bad;
    int                pick, n, k;
    logic              seq;
    pick = $urandom_range(99);
    seq = 1'($urandom_range(1));
    n = $urandom_range(1, 10);
    pay = {};
    repeat (n) pay.push_back(pick_octet());
    if (pick < 60) begin
      send_frame(seq, pay, 1'b1, '0, 1'b0);
    end else if (pick < 70) begin
      send_frame(seq, pay, 1'b1, DATA_W'($urandom_range(1, 255)), 1'b0);
    end else if (pick < 75) begin
      // nothing, or only the BCC2 byte, between header and closing flag
      pay = {};
      send_frame(seq, pay, 1'($urandom_range(1)), '0, 1'b0);
    end else if (pick < 80) begin
      send_frame(seq, pay, 1'b1, '0, 1'b1);
    end else if (pick < 90) begin
      ctl = cur.info_ctl | {1'b0, seq, 6'b0};
      hdr[0] = cur.flag;
      hdr[1] = cur.cmd_addr;
      hdr[2] = ctl;
      hdr[3] = ctl ^ cur.cmd_addr;
      k = $urandom_range(1, 3);
      // a damaged header byte that is itself a flag drops to flag-seen
      if ($urandom_range(3) == 0 && cur.flag != hdr[k]) begin
        bad = cur.flag;
      end else begin
        do bad = DATA_W'($urandom_range(255)); while (bad == hdr[k]);
      end
      hdr[k] = bad;
      foreach (hdr[i]) send_byte(hdr[i]);
      foreach (pay[i]) send_byte(pay[i]);
      send_byte(cur.flag);
    end else begin
      repeat ($urandom_range(1, 6)) send_byte(pick_octet());
    end
  endtask

  initial begin
    octet_q_t pay;
    int       start;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames at reset settings.
    // Good frame, sequence 0: payload holds flag, escape, 0x00 and 0xFF.
    pay = {cur.flag, cur.escape, 8'h00, 8'hFF};
    send_frame(1'b0, pay, 1'b1, '0, 1'b0);
    // Sequence 1, closing flag right after the header: empty, bad.
    pay = {};
    send_frame(1'b1, pay, 1'b0, '0, 1'b0);
    // Sequence 1, escape still open when the closing flag comes.
    pay = {8'h55};
    send_frame(1'b1, pay, 1'b1, '0, 1'b1);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          cur = '{flag: 8'h00, escape: 8'hFF, cmd_addr: 8'hFF,
                  info_ctl: 8'h00, ack_ctl: 8'hFF, nack_ctl: 8'h00};
          resp_val = 8'h00;
        end
        1: begin
          // info control with bit 6 set: both sequences share one control byte
          cur = '{flag: 8'hFF, escape: 8'h00, cmd_addr: 8'h00,
                  info_ctl: 8'hFF, ack_ctl: 8'h00, nack_ctl: 8'hFF};
          resp_val = 8'hFF;
        end
        N_PHASES - 1: begin
          cur = '{flag: FLAG_RST, escape: ESCAPE_RST, cmd_addr: CMD_ADDR_RST,
                  info_ctl: INFO_CTL_RST, ack_ctl: ACK_CTL_RST, nack_ctl: NACK_CTL_RST};
          resp_val = RESP_ADDR_RST;
        end
        default: begin
          cur.flag = DATA_W'($urandom_range(255));
          // escape must differ from flag and from flag ^ 0x20, or some
          // payload values could not be stuffed
          do cur.escape = DATA_W'($urandom_range(255));
          while (cur.escape == cur.flag || cur.escape == (cur.flag ^ STUFF_XOR));
          cur.cmd_addr = DATA_W'($urandom_range(255));
          cur.info_ctl = DATA_W'($urandom_range(255));
          cur.ack_ctl = DATA_W'($urandom_range(255));
          cur.nack_ctl = DATA_W'($urandom_range(255));
          resp_val = DATA_W'($urandom_range(255));
        end
      endcase
      apply_config();

      // One phase runs flat out on both sides.
      src_idle = (ph == 3) ? 0 : IDLE_PCT;
      sink_idle <= (ph == 3) ? 0 : IDLE_PCT;

      start = sent;
      while (sent - start < PHASE_ITEMS) begin
        send_random_frame();
        if ($urandom_range(99) < 3) wait_idle();
      end

      if (ph == N_PHASES - 1) begin
        // Largest payload that fits, then one byte past it (overflow).
        pay = {};
        repeat (MAX_PAYLOAD_DEF) pay.push_back(pick_octet());
        send_frame(1'($urandom_range(1)), pay, 1'b1, '0, 1'b0);
        pay.push_back(pick_octet());
        send_frame(1'($urandom_range(1)), pay, 1'b1, '0, 1'b0);
      end
    end

    push <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (20) @(posedge clk);

    $display("run covered %0d input bytes over %0d register settings, incl. overflow frames",
             sent, N_PHASES + 1);
    $display("checked %0d payload bytes, %0d good and %0d bad frame ends",
             data_seen, good_seen, bad_seen);
    if (fail_count == 0) begin
      $display("tb_info_frame_deframer_checker passed");
    end else begin
      $display("tb_info_frame_deframer_checker failed");
    end
    $finish;
  end

endmodule
